### rtl/cbc_pkg.sv
// Shared types, constants and helpers for the circle/box contact block.
package cbc_pkg;

  localparam int CW     = 32;          // coordinate width
  localparam int FB     = 16;          // fraction bits
  localparam int RW     = CW - 1;      // unsigned radius, size and depth width
  localparam int NW     = FB + 2;      // normal component width
  localparam int DW     = CW + 2;      // front difference width
  localparam int SQW    = 2 * CW;      // square root working width
  localparam int DSQW   = 2 * RW + 1;  // squared distance width
  localparam int DS     = FB + 1;      // divider stages, one quotient bit each
  localparam int CFG_W  = 16;
  localparam int CFG_IW = 8;
  localparam int QDEPTH = 8;
  localparam int QAW    = 3;
  localparam int QCW    = QAW + 1;

  typedef enum logic [CFG_IW-1:0] {
    CFG_VMARGIN = 8'd0,
    CFG_FLOOR   = 8'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    SIDE_XN,
    SIDE_XP,
    SIDE_ZN,
    SIDE_ZP
  } side_e;

  typedef struct packed {
    logic [CW-1:0] px;
    logic [CW-1:0] py;
    logic [CW-1:0] pz;
    logic [RW-1:0] r;
    logic [CW-1:0] cx;
    logic [CW-1:0] cy;
    logic [CW-1:0] cz;
    logic [RW-1:0] sx;
    logic [CW-1:0] sy;
    logic [RW-1:0] sz;
    logic [CW-1:0] amin;
    logic [CW-1:0] amax;
  } in_t;

  // Classified request as it sits in the queue between front and back.
  typedef struct packed {
    logic          overlap;
    logic          near;
    logic          dx_neg;
    logic [RW-1:0] dx_mag;
    logic          dz_neg;
    logic [RW-1:0] dz_mag;
    logic [RW-1:0] r;
    logic [CW-1:0] px;
    logic [CW-1:0] py;
    logic [CW-1:0] pz;
    logic [CW:0]   minx;
    logic [CW:0]   maxx;
    logic [CW:0]   minz;
    logic [CW:0]   maxz;
    logic [CW:0]   qx;
    logic [CW:0]   qz;
    logic [DW-1:0] dl;
    logic [DW-1:0] dr;
    logic [DW-1:0] ds;
    logic [DW-1:0] dn;
  } item_t;

  // Payload carried down the square root and divider stages.
  typedef struct packed {
    logic          overlap;
    logic          hit;
    logic          outside;
    side_e         side;
    logic [RW-1:0] pen_in;
    logic [CW-1:0] in_ox;
    logic [CW-1:0] in_oz;
    logic [CW-1:0] qx_s;
    logic [CW-1:0] qz_s;
    logic [CW-1:0] py;
    logic [RW-1:0] r;
    logic          dx_neg;
    logic          dz_neg;
    logic [RW-1:0] dx_mag;
    logic [RW-1:0] dz_mag;
  } pl_t;

  typedef struct packed {
    logic          span_overlap;
    logic          contact;
    logic [NW-1:0] nx;
    logic [NW-1:0] nz;
    logic [RW-1:0] pen;
    logic [CW-1:0] ptx;
    logic [CW-1:0] pty;
    logic [CW-1:0] ptz;
  } res_t;

  function automatic logic [CW-1:0] sat_coord(input logic [CW:0] v);
    logic [CW-1:0] res;
    if (v[CW] != v[CW-1]) begin
      res = v[CW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    end else begin
      res = v[CW-1:0];
    end
    return res;
  endfunction

endpackage

### rtl/cbc_front.sv
// Front end: registers requests, runs the vertical span test, clamps and classifies.
module cbc_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  cbc_pkg::in_t               in_i,
  input  logic [cbc_pkg::CFG_W-1:0]  margin_i,
  output logic                       item_valid_o,
  output cbc_pkg::item_t             item_o,
  output logic [1:0]                 inflight_o
);
  import cbc_pkg::*;

  typedef struct packed {
    logic [DW-1:0] lo;
    logic [DW-1:0] hi;
    logic [CW-1:0] amin;
    logic [CW-1:0] amax;
    logic [CW:0]   minx;
    logic [CW:0]   maxx;
    logic [CW:0]   minz;
    logic [CW:0]   maxz;
    logic [CW-1:0] px;
    logic [CW-1:0] py;
    logic [CW-1:0] pz;
    logic [RW-1:0] r;
  } bnd_t;

  logic    a_v_q, b_v_q;
  in_t     a_q;
  bnd_t    b_q, b_d;
  logic    swap;
  logic [CW-1:0] hy;
  logic [CW:0]   pxe, pze;
  logic [DW-1:0] dx, dz, mx, mz;

  always_comb begin
    swap   = $signed(a_q.amin) > $signed(a_q.amax);
    b_d.amin = swap ? a_q.amax : a_q.amin;
    b_d.amax = swap ? a_q.amin : a_q.amax;
    hy     = a_q.sy[CW-1] ? '0 : {1'b0, a_q.sy[CW-1:1]};
    b_d.lo = {{2{a_q.cy[CW-1]}}, a_q.cy} - {2'b00, hy}
             + {{(DW-CFG_W){1'b0}}, margin_i};
    b_d.hi = {{2{a_q.cy[CW-1]}}, a_q.cy} + {2'b00, hy}
             - {{(DW-CFG_W){1'b0}}, margin_i};
    b_d.minx = {a_q.cx[CW-1], a_q.cx} - {{(CW+2-RW){1'b0}}, a_q.sx[RW-1:1]};
    b_d.maxx = {a_q.cx[CW-1], a_q.cx} + {{(CW+2-RW){1'b0}}, a_q.sx[RW-1:1]};
    b_d.minz = {a_q.cz[CW-1], a_q.cz} - {{(CW+2-RW){1'b0}}, a_q.sz[RW-1:1]};
    b_d.maxz = {a_q.cz[CW-1], a_q.cz} + {{(CW+2-RW){1'b0}}, a_q.sz[RW-1:1]};
    b_d.px = a_q.px;
    b_d.py = a_q.py;
    b_d.pz = a_q.pz;
    b_d.r  = a_q.r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
    end else begin
      a_v_q <= in_valid_i;
      b_v_q <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i) begin
      a_q <= in_i;
    end
    if (a_v_q) begin
      b_q <= b_d;
    end
  end

  always_comb begin
    pxe = {b_q.px[CW-1], b_q.px};
    pze = {b_q.pz[CW-1], b_q.pz};
    item_o.overlap = ($signed({{2{b_q.amax[CW-1]}}, b_q.amax}) > $signed(b_q.lo)) &&
                     ($signed({{2{b_q.amin[CW-1]}}, b_q.amin}) < $signed(b_q.hi));
    if ($signed(pxe) < $signed(b_q.minx)) begin
      item_o.qx = b_q.minx;
    end else if ($signed(pxe) > $signed(b_q.maxx)) begin
      item_o.qx = b_q.maxx;
    end else begin
      item_o.qx = pxe;
    end
    if ($signed(pze) < $signed(b_q.minz)) begin
      item_o.qz = b_q.minz;
    end else if ($signed(pze) > $signed(b_q.maxz)) begin
      item_o.qz = b_q.maxz;
    end else begin
      item_o.qz = pze;
    end
    dx = {pxe[CW], pxe} - {item_o.qx[CW], item_o.qx};
    dz = {pze[CW], pze} - {item_o.qz[CW], item_o.qz};
    mx = dx[DW-1] ? (~dx + 1'b1) : dx;
    mz = dz[DW-1] ? (~dz + 1'b1) : dz;
    item_o.near = (mx < {{(DW-RW){1'b0}}, b_q.r}) && (mz < {{(DW-RW){1'b0}}, b_q.r});
    item_o.dx_neg = dx[DW-1];
    item_o.dz_neg = dz[DW-1];
    item_o.dx_mag = mx[RW-1:0];
    item_o.dz_mag = mz[RW-1:0];
    item_o.r    = b_q.r;
    item_o.px   = b_q.px;
    item_o.py   = b_q.py;
    item_o.pz   = b_q.pz;
    item_o.minx = b_q.minx;
    item_o.maxx = b_q.maxx;
    item_o.minz = b_q.minz;
    item_o.maxz = b_q.maxz;
    item_o.dl = {pxe[CW], pxe} - {b_q.minx[CW], b_q.minx};
    item_o.dr = {b_q.maxx[CW], b_q.maxx} - {pxe[CW], pxe};
    item_o.ds = {pze[CW], pze} - {b_q.minz[CW], b_q.minz};
    item_o.dn = {b_q.maxz[CW], b_q.maxz} - {pze[CW], pze};
  end

  assign item_valid_o = b_v_q;
  assign inflight_o   = {1'b0, a_v_q} + {1'b0, b_v_q};

endmodule

### rtl/cbc_queue.sv
// Short queue of classified requests between the front and the back.
module cbc_queue (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  input  cbc_pkg::item_t           item_i,
  input  logic                     pop_i,
  output cbc_pkg::item_t           head_o,
  output logic                     empty_o,
  output logic [cbc_pkg::QCW-1:0]  cnt_o
);
  import cbc_pkg::*;

  item_t          mem_q [QDEPTH];
  logic [QAW-1:0] wptr_q, rptr_q;
  logic [QCW-1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= rptr_q + 1'b1;
      end
      cnt_q <= cnt_q + {{(QCW-1){1'b0}}, push_i} - {{(QCW-1){1'b0}}, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= item_i;
    end
  end

  assign head_o  = mem_q[rptr_q];
  assign empty_o = (cnt_q == '0);
  assign cnt_o   = cnt_q;

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |-> cnt_q < QCW'(QDEPTH))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> cnt_q != '0)
    else $error("queue read while empty");

endmodule

### rtl/cbc_back.sv
// Back end: squares, inside-case selection, pipelined square root and divide.
module cbc_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cbc_pkg::item_t            head_i,
  input  logic                      q_empty_i,
  output logic                      q_pop_o,
  input  logic [cbc_pkg::CFG_W-1:0] floor_i,
  input  logic                      pop_i,
  output logic                      res_valid_o,
  output cbc_pkg::res_t             res_o
);
  import cbc_pkg::*;

  localparam logic [FB:0]    ONE_Q = {1'b1, {FB{1'b0}}};
  localparam logic [NW-1:0]  ONE_N = {2'b01, {FB{1'b0}}};

  logic adv;
  logic out_v_q;
  res_t out_q, out_d;

  // The whole pipeline moves together and holds while the result is not taken.
  assign adv     = !out_v_q || pop_i;
  assign q_pop_o = adv && !q_empty_i;

  // Stage P0: dequeued request.
  logic  p0_v_q;
  item_t p0_q;

  // Stage P1: squares and the inside-case answer.
  logic              p1_v_q;
  logic              p1_near_q;
  logic [DSQW-1:0]   p1_dsq_q;
  logic [2*RW-1:0]   p1_rsq_q;
  pl_t               p1_q, p1_d;
  logic [2*RW-1:0]   sqx_d, sqz_d;
  logic [DSQW-1:0]   dsq_d;
  logic [2*RW-1:0]   rsq_d;
  logic [DW-1:0]     best;
  logic [DW:0]       pen_sum;

  always_comb begin
    sqx_d = p0_q.dx_mag * p0_q.dx_mag;
    sqz_d = p0_q.dz_mag * p0_q.dz_mag;
    dsq_d = {1'b0, sqx_d} + {1'b0, sqz_d};
    rsq_d = p0_q.r * p0_q.r;
    best      = p0_q.dl;
    p1_d.side = SIDE_XN;
    if ($signed(p0_q.dr) < $signed(best)) begin
      best = p0_q.dr;
      p1_d.side = SIDE_XP;
    end
    if ($signed(p0_q.ds) < $signed(best)) begin
      best = p0_q.ds;
      p1_d.side = SIDE_ZN;
    end
    if ($signed(p0_q.dn) < $signed(best)) begin
      best = p0_q.dn;
      p1_d.side = SIDE_ZP;
    end
    pen_sum = {best[DW-1], best} + {{(DW+1-RW){1'b0}}, p0_q.r};
    if (pen_sum[DW]) begin
      p1_d.pen_in = '0;
    end else if ($signed(pen_sum) > $signed({{(DW+1-RW){1'b0}}, {RW{1'b1}}})) begin
      p1_d.pen_in = {RW{1'b1}};
    end else begin
      p1_d.pen_in = pen_sum[RW-1:0];
    end
    case (p1_d.side)
      SIDE_XN: begin
        p1_d.in_ox = sat_coord(p0_q.minx);
        p1_d.in_oz = p0_q.pz;
      end
      SIDE_XP: begin
        p1_d.in_ox = sat_coord(p0_q.maxx);
        p1_d.in_oz = p0_q.pz;
      end
      SIDE_ZN: begin
        p1_d.in_ox = p0_q.px;
        p1_d.in_oz = sat_coord(p0_q.minz);
      end
      default: begin
        p1_d.in_ox = p0_q.px;
        p1_d.in_oz = sat_coord(p0_q.maxz);
      end
    endcase
    p1_d.overlap = p0_q.overlap;
    p1_d.hit     = 1'b0;
    p1_d.outside = 1'b0;
    p1_d.qx_s    = sat_coord(p0_q.qx);
    p1_d.qz_s    = sat_coord(p0_q.qz);
    p1_d.py      = p0_q.py;
    p1_d.r       = p0_q.r;
    p1_d.dx_neg  = p0_q.dx_neg;
    p1_d.dz_neg  = p0_q.dz_neg;
    p1_d.dx_mag  = p0_q.dx_mag;
    p1_d.dz_mag  = p0_q.dz_mag;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p0_v_q <= 1'b0;
      p1_v_q <= 1'b0;
    end else if (adv) begin
      p0_v_q <= !q_empty_i;
      p1_v_q <= p0_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p0_q      <= head_i;
      p1_q      <= p1_d;
      p1_near_q <= p0_q.near;
      p1_dsq_q  <= dsq_d;
      p1_rsq_q  <= rsq_d;
    end
  end

  // Square root, one result bit per stage.
  logic [SQW-1:0] sv  [CW+1];
  logic [SQW-1:0] sr  [CW+1];
  pl_t            spl [CW+1];
  logic           svl [CW+1];

  always_comb begin
    spl[0]         = p1_q;
    spl[0].hit     = p1_q.overlap && p1_near_q && ({1'b0, p1_rsq_q} > p1_dsq_q);
    spl[0].outside = p1_dsq_q > {{(DSQW-CFG_W){1'b0}}, floor_i};
  end
  assign sv[0]  = {{(SQW-DSQW){1'b0}}, p1_dsq_q};
  assign sr[0]  = '0;
  assign svl[0] = p1_v_q;

  for (genvar k = 0; k < CW; k++) begin : g_sqrt
    localparam logic [SQW-1:0] BIT = {{(SQW-1){1'b0}}, 1'b1} << (SQW - 2 - 2 * k);
    logic [SQW-1:0] trial;
    logic           ge;
    assign trial = sr[k] + BIT;
    assign ge    = sv[k] >= trial;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        svl[k+1] <= 1'b0;
      end else if (adv) begin
        svl[k+1] <= svl[k];
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        sv[k+1]  <= ge ? sv[k] - trial : sv[k];
        sr[k+1]  <= ge ? (sr[k] >> 1) + BIT : (sr[k] >> 1);
        spl[k+1] <= spl[k];
      end
    end
  end

  // Restoring divide of each magnitude by the distance, one quotient bit per stage.
  logic [RW:0]   rx  [DS+1];
  logic [RW:0]   rz  [DS+1];
  logic [FB:0]   qx  [DS+1];
  logic [FB:0]   qz  [DS+1];
  logic [RW-1:0] dd  [DS+1];
  pl_t           dpl [DS+1];
  logic          dvl [DS+1];

  assign rx[0]  = {1'b0, spl[CW].dx_mag};
  assign rz[0]  = {1'b0, spl[CW].dz_mag};
  assign qx[0]  = '0;
  assign qz[0]  = '0;
  assign dd[0]  = sr[CW][RW-1:0];
  assign dpl[0] = spl[CW];
  assign dvl[0] = svl[CW];

  for (genvar j = 0; j < DS; j++) begin : g_div
    logic [RW:0] tx, tz;
    logic        gx, gz;
    // The first step takes the magnitude as it is, since it never exceeds the distance.
    assign tx = (j == 0) ? rx[j] : {rx[j][RW-1:0], 1'b0};
    assign tz = (j == 0) ? rz[j] : {rz[j][RW-1:0], 1'b0};
    assign gx = tx >= {1'b0, dd[j]};
    assign gz = tz >= {1'b0, dd[j]};
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dvl[j+1] <= 1'b0;
      end else if (adv) begin
        dvl[j+1] <= dvl[j];
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        rx[j+1]  <= gx ? tx - {1'b0, dd[j]} : tx;
        rz[j+1]  <= gz ? tz - {1'b0, dd[j]} : tz;
        qx[j+1]  <= {qx[j][FB-1:0], gx};
        qz[j+1]  <= {qz[j][FB-1:0], gz};
        dd[j+1]  <= dd[j];
        dpl[j+1] <= dpl[j];
      end
    end
  end

  pl_t         fpl;
  logic [FB:0] cqx, cqz;

  always_comb begin
    fpl = dpl[DS];
    cqx = (qx[DS] > ONE_Q) ? ONE_Q : qx[DS];
    cqz = (qz[DS] > ONE_Q) ? ONE_Q : qz[DS];
    out_d = '0;
    out_d.span_overlap = fpl.overlap;
    if (fpl.hit) begin
      out_d.contact = 1'b1;
      out_d.pty     = fpl.py;
      if (fpl.outside) begin
        out_d.nx  = fpl.dx_neg ? (~{1'b0, cqx} + 1'b1) : {1'b0, cqx};
        out_d.nz  = fpl.dz_neg ? (~{1'b0, cqz} + 1'b1) : {1'b0, cqz};
        out_d.pen = fpl.r - dd[DS];
        out_d.ptx = fpl.qx_s;
        out_d.ptz = fpl.qz_s;
      end else begin
        case (fpl.side)
          SIDE_XN: out_d.nx = ~ONE_N + 1'b1;
          SIDE_XP: out_d.nx = ONE_N;
          SIDE_ZN: out_d.nz = ~ONE_N + 1'b1;
          default: out_d.nz = ONE_N;
        endcase
        out_d.pen = fpl.pen_in;
        out_d.ptx = fpl.in_ox;
        out_d.ptz = fpl.in_oz;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= dvl[DS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign res_valid_o = out_v_q;
  assign res_o       = out_q;

endmodule

### rtl/circle_box_contact.sv
// Top level of the circle/box contact block: ports, configuration and credit control.
//
//   channel   direction  handshake             contents
//   request   in         push / full           actor, circle and box fields
//   result    out        empty / pop           overlap, contact, normal, depth, point
//   config    in         cfg_valid / cfg_ready register index and 16-bit data
//
// One request is taken per cycle while full is low. A request passes from acceptance to the
// result ports through two front stages, the queue write, two back stages, a 32-stage square
// root, a 17-stage divider and the output register. Reset leaves no memory to clear. When a
// result is not popped the whole back pipeline holds, the queue fills and full rises.
module circle_box_contact (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic [cbc_pkg::CW-1:0]      pos_x_i,
  input  logic [cbc_pkg::CW-1:0]      pos_y_i,
  input  logic [cbc_pkg::CW-1:0]      pos_z_i,
  input  logic [cbc_pkg::RW-1:0]      circle_radius_i,
  input  logic [cbc_pkg::CW-1:0]      box_center_x_i,
  input  logic [cbc_pkg::CW-1:0]      box_center_y_i,
  input  logic [cbc_pkg::CW-1:0]      box_center_z_i,
  input  logic [cbc_pkg::RW-1:0]      box_size_x_i,
  input  logic [cbc_pkg::CW-1:0]      box_size_y_i,
  input  logic [cbc_pkg::RW-1:0]      box_size_z_i,
  input  logic [cbc_pkg::CW-1:0]      actor_min_y_i,
  input  logic [cbc_pkg::CW-1:0]      actor_max_y_i,
  output logic                        empty,
  input  logic                        pop,
  output logic                        span_overlap_o,
  output logic                        contact_o,
  output logic [cbc_pkg::NW-1:0]      normal_x_o,
  output logic [cbc_pkg::NW-1:0]      normal_z_o,
  output logic [cbc_pkg::RW-1:0]      penetration_o,
  output logic [cbc_pkg::CW-1:0]      point_x_o,
  output logic [cbc_pkg::CW-1:0]      point_y_o,
  output logic [cbc_pkg::CW-1:0]      point_z_o,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [cbc_pkg::CFG_IW-1:0]  cfg_index_i,
  input  logic [cbc_pkg::CFG_W-1:0]   cfg_data_i
);
  import cbc_pkg::*;

  logic [CFG_W-1:0] margin_q, floor_q;
  in_t              in_req;
  logic             accept;
  logic             item_valid;
  item_t            item, head;
  logic [1:0]       inflight;
  logic             q_empty, q_pop;
  logic [QCW-1:0]   q_cnt;
  logic             res_valid;
  res_t             res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      margin_q <= CFG_W'(66);
      floor_q  <= CFG_W'(1);
    end else if (cfg_valid) begin
      case (cfg_index_i)
        CFG_VMARGIN: margin_q <= cfg_data_i;
        CFG_FLOOR:   floor_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Requests still in the front stages already hold a queue slot.
  assign full   = ({1'b0, q_cnt} + {{(QCW-1){1'b0}}, inflight}) >= (QCW+1)'(QDEPTH);
  assign accept = push && !full;

  assign in_req.px   = pos_x_i;
  assign in_req.py   = pos_y_i;
  assign in_req.pz   = pos_z_i;
  assign in_req.r    = circle_radius_i;
  assign in_req.cx   = box_center_x_i;
  assign in_req.cy   = box_center_y_i;
  assign in_req.cz   = box_center_z_i;
  assign in_req.sx   = box_size_x_i;
  assign in_req.sy   = box_size_y_i;
  assign in_req.sz   = box_size_z_i;
  assign in_req.amin = actor_min_y_i;
  assign in_req.amax = actor_max_y_i;

  cbc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (accept),
    .in_i         (in_req),
    .margin_i     (margin_q),
    .item_valid_o (item_valid),
    .item_o       (item),
    .inflight_o   (inflight)
  );

  cbc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (item_valid),
    .item_i  (item),
    .pop_i   (q_pop),
    .head_o  (head),
    .empty_o (q_empty),
    .cnt_o   (q_cnt)
  );

  cbc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .q_empty_i   (q_empty),
    .q_pop_o     (q_pop),
    .floor_i     (floor_q),
    .pop_i       (pop),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign empty          = !res_valid;
  assign span_overlap_o = res.span_overlap;
  assign contact_o      = res.contact;
  assign normal_x_o     = res.nx;
  assign normal_z_o     = res.nz;
  assign penetration_o  = res.pen;
  assign point_x_o      = res.ptx;
  assign point_y_o      = res.pty;
  assign point_z_o      = res.ptz;

  a_contact_needs_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && contact_o |-> span_overlap_o)
    else $error("contact reported without span overlap");
  a_miss_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !contact_o |-> penetration_o == '0 && point_y_o == '0)
    else $error("miss carries nonzero result fields");

endmodule
